[hdl/lae_pkg.sv]
// Shared types and constants of the linear ADSR envelope generator.
// Used by lae_ctrl, lae_dpath and linear_adsr_envelope; depends on nothing.
package lae_pkg;

    localparam int unsigned SR_W    = 18;
    localparam int unsigned TIME_W  = 19;
    localparam int unsigned SUS_W   = 25;
    localparam int unsigned CV_W    = 21;
    localparam int unsigned OUT_W   = 20;
    localparam int unsigned CFG_W   = 25;
    localparam int unsigned CFGI_W  = 3;
    localparam int unsigned TSEL_W  = 20;
    localparam int unsigned DEN_W   = SR_W + TSEL_W;
    localparam int unsigned NUM_W   = 41;
    localparam int unsigned QUO_W   = 25;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned LVL_W   = 27;

    localparam logic [SUS_W-1:0] ONE_Q24  = 25'd16777216;
    localparam logic [SUS_W-1:0] HALF_Q24 = 25'd8388608;
    localparam logic [SUS_W-1:0] SUS_TOL  = 25'd16777;
    localparam logic signed [CV_W-1:0] GATE_THRESH = 21'sd65536;
    localparam logic signed [CV_W-1:0] CV_ONE_VOLT = 21'sd65536;
    localparam logic [CNT_W-1:0] LAST_BIT = 5'd24;

    typedef enum logic [CFGI_W-1:0] {
        CFG_SAMPLE_RATE = 3'd0,
        CFG_ATTACK      = 3'd1,
        CFG_DECAY       = 3'd2,
        CFG_SUSTAIN     = 3'd3,
        CFG_RELEASE     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic load;
        logic mul;
        logic init;
        logic step;
        logic upd;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic out_busy;
    } t_status;

endpackage

[hdl/lae_ctrl.sv]
// Sequencing state machine of the envelope generator.
// Depends on lae_pkg for the command and status structs.
module lae_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  lae_pkg::t_status  i_status,
    output logic              o_in_ready,
    output lae_pkg::t_cmd     o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_INIT = 5'b00100,
        S_DIV  = 5'b01000,
        S_UPD  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_INIT;
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.cnt_zero) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (!i_status.out_busy) begin
                    o_cmd.upd = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

[hdl/lae_dpath.sv]
// Datapath: knob registers, step multipliers, three bit-serial dividers,
// envelope state and the output register. Depends on lae_pkg.
module lae_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lae_pkg::t_cmd                     i_cmd,
    output lae_pkg::t_status                  o_status,
    input  logic                              i_cfg_we,
    input  logic [lae_pkg::CFGI_W-1:0]        i_cfg_index,
    input  logic [lae_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic signed [lae_pkg::CV_W-1:0]   i_gate_volts,
    input  logic signed [lae_pkg::CV_W-1:0]   i_attack_cv,
    input  logic                              i_attack_cv_on,
    input  logic signed [lae_pkg::CV_W-1:0]   i_decay_cv,
    input  logic                              i_decay_cv_on,
    input  logic signed [lae_pkg::CV_W-1:0]   i_sustain_cv,
    input  logic                              i_sustain_cv_on,
    input  logic signed [lae_pkg::CV_W-1:0]   i_release_cv,
    input  logic                              i_release_cv_on,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [lae_pkg::OUT_W-1:0]         o_env_out
);

    localparam int unsigned SW = lae_pkg::SUS_W;
    localparam int unsigned LW = lae_pkg::LVL_W;
    localparam int unsigned DW = lae_pkg::DEN_W;

    logic [lae_pkg::SR_W-1:0]   r_sr;
    logic [lae_pkg::TIME_W-1:0] r_ak, r_dk, r_rk;
    logic [SW-1:0]              r_sk;

    logic [lae_pkg::TSEL_W-1:0] r_time [3];
    logic [SW-1:0]              r_sus;
    logic                       r_gate;
    logic [lae_pkg::DEN_W-1:0]  r_den  [3];
    logic [lae_pkg::NUM_W-1:0]  r_num  [3];
    logic [lae_pkg::DEN_W:0]    r_rem  [3];
    logic [lae_pkg::QUO_W-1:0]  r_quo  [3];
    logic                       r_ovf  [3];
    logic [lae_pkg::CNT_W-1:0]  r_cnt;

    logic [SW-1:0] r_level;
    logic          r_attacking, r_running, r_gate_was_high;
    logic          r_out_valid;
    logic [lae_pkg::OUT_W-1:0] r_out;

    function automatic logic [lae_pkg::TSEL_W-1:0] pick_time(
        input logic signed [lae_pkg::CV_W-1:0] cv,
        input logic                            on,
        input logic [lae_pkg::TIME_W-1:0]      knob
    );
        logic [lae_pkg::TSEL_W-1:0] t;
        if (on) begin
            t = cv[lae_pkg::CV_W-1] ? '0 : cv[lae_pkg::TSEL_W-1:0];
        end else begin
            t = {1'b0, knob};
        end
        return t;
    endfunction

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr <= 18'd48000;
            r_ak <= 19'd32768;
            r_dk <= 19'd32768;
            r_sk <= 25'd8388608;
            r_rk <= 19'd32768;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lae_pkg::CFG_SAMPLE_RATE: r_sr <= i_cfg_data[lae_pkg::SR_W-1:0];
                lae_pkg::CFG_ATTACK:      r_ak <= i_cfg_data[lae_pkg::TIME_W-1:0];
                lae_pkg::CFG_DECAY:       r_dk <= i_cfg_data[lae_pkg::TIME_W-1:0];
                lae_pkg::CFG_SUSTAIN:     r_sk <= i_cfg_data[SW-1:0];
                lae_pkg::CFG_RELEASE:     r_rk <= i_cfg_data[lae_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Sustain selection with saturation.
    logic [SW-1:0] sus_sel;
    always_comb begin
        if (i_sustain_cv_on) begin
            if (i_sustain_cv[lae_pkg::CV_W-1]) begin
                sus_sel = '0;
            end else if (i_sustain_cv > lae_pkg::CV_ONE_VOLT) begin
                sus_sel = lae_pkg::ONE_Q24;
            end else begin
                sus_sel = {i_sustain_cv[16:0], 8'b0};
            end
        end else begin
            sus_sel = (r_sk > lae_pkg::ONE_Q24) ? lae_pkg::ONE_Q24 : r_sk;
        end
    end

    // Divider lanes: attack, decay, release.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_time[0] <= pick_time(i_attack_cv, i_attack_cv_on, r_ak);
            r_time[1] <= pick_time(i_decay_cv, i_decay_cv_on, r_dk);
            r_time[2] <= pick_time(i_release_cv, i_release_cv_on, r_rk);
            r_sus     <= sus_sel;
            r_gate    <= (i_gate_volts >= lae_pkg::GATE_THRESH);
        end
        if (i_cmd.mul) begin
            for (int i = 0; i < 3; i++) begin
                r_den[i] <= DW'(r_sr) * DW'(r_time[i]);
            end
            r_num[0] <= {1'b1, 40'b0};
            r_num[1] <= {lae_pkg::ONE_Q24 - r_sus, 16'b0};
            r_num[2] <= {r_sus, 16'b0};
        end
        if (i_cmd.init) begin
            for (int i = 0; i < 3; i++) begin
                r_rem[i] <= {23'b0, r_num[i][lae_pkg::NUM_W-1:lae_pkg::QUO_W]};
                r_ovf[i] <= ({22'b0, r_num[i][lae_pkg::NUM_W-1:lae_pkg::QUO_W]} >= r_den[i]);
                r_quo[i] <= '0;
            end
            r_cnt <= lae_pkg::LAST_BIT;
        end
        if (i_cmd.step) begin
            for (int i = 0; i < 3; i++) begin
                logic [lae_pkg::QUO_W-1:0] lo;
                logic [lae_pkg::DEN_W:0]   rs;
                logic                      ge;
                lo = r_num[i][lae_pkg::QUO_W-1:0];
                rs = {r_rem[i][lae_pkg::DEN_W-1:0], lo[r_cnt]};
                ge = (rs >= {1'b0, r_den[i]});
                r_rem[i] <= ge ? rs - {1'b0, r_den[i]} : rs;
                r_quo[i] <= {r_quo[i][lae_pkg::QUO_W-2:0], ge};
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Step clamping and level update.
    logic [SW-1:0] astep, dmag, rmag;
    logic signed [LW-1:0] lvl, rstep, sus_s, n_lvl_raw;
    logic [SW-1:0] n_level;
    logic n_attacking, n_running;
    logic [28:0] times10;

    always_comb begin
        if (r_ovf[0] || r_quo[0] > lae_pkg::HALF_Q24) begin
            astep = lae_pkg::HALF_Q24;
        end else if (r_quo[0] == '0) begin
            astep = SW'(1);
        end else begin
            astep = r_quo[0];
        end
        if (r_num[1] == '0) begin
            dmag = '0;
        end else if (r_ovf[1] || r_quo[1] > lae_pkg::HALF_Q24) begin
            dmag = lae_pkg::HALF_Q24;
        end else begin
            dmag = r_quo[1];
        end
        if (r_ovf[2] || r_quo[2] > lae_pkg::ONE_Q24) begin
            rmag = lae_pkg::ONE_Q24;
        end else if (r_quo[2] == '0) begin
            rmag = SW'(1);
        end else begin
            rmag = r_quo[2];
        end

        lvl         = $signed({2'b0, r_level});
        rstep       = -$signed({2'b0, rmag});
        sus_s       = $signed({2'b0, r_sus});
        n_attacking = r_attacking;
        n_running   = r_running;
        if (r_gate && !r_gate_was_high) begin
            n_attacking = 1'b1;
            n_running   = 1'b1;
        end
        n_lvl_raw = lvl;
        if (n_running) begin
            if (r_gate) begin
                if (n_attacking) begin
                    n_lvl_raw = lvl + $signed({2'b0, astep});
                    if (n_lvl_raw >= $signed({2'b0, lae_pkg::ONE_Q24})) begin
                        n_attacking = 1'b0;
                    end
                end else if (lvl <= sus_s + $signed({2'b0, lae_pkg::SUS_TOL})) begin
                    n_lvl_raw = sus_s;
                end else begin
                    n_lvl_raw = lvl - $signed({2'b0, dmag});
                end
            end else begin
                n_lvl_raw = lvl + rstep;
                if (n_lvl_raw <= rstep) begin
                    n_running = 1'b0;
                end
            end
        end else begin
            n_lvl_raw = '0;
        end
        if (n_lvl_raw > $signed({2'b0, lae_pkg::ONE_Q24})) begin
            n_level = lae_pkg::ONE_Q24;
        end else if (n_lvl_raw < 0) begin
            n_level = '0;
        end else begin
            n_level = n_lvl_raw[SW-1:0];
        end
        times10 = {1'b0, n_level, 3'b0} + {3'b0, n_level, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level         <= '0;
            r_attacking     <= 1'b0;
            r_running       <= 1'b0;
            r_gate_was_high <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cmd.upd) begin
                r_level         <= n_level;
                r_attacking     <= n_attacking;
                r_running       <= n_running;
                r_gate_was_high <= r_gate;
                r_out_valid     <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_out <= times10[27:8];
        end
    end

    assign o_status.cnt_zero = (r_cnt == '0);
    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_env_out         = r_out;

endmodule

[hdl/linear_adsr_envelope.sv]
// Top level of the linear ADSR envelope generator.
// Instantiates lae_ctrl and lae_dpath; depends on lae_pkg.
//
// One transaction on the input channel is one audio sample and yields exactly
// one output transaction carrying the envelope value. Each sample passes
// through capture, the three time-by-rate products, the divider set-up, the
// bit-serial dividers (one quotient bit per cycle, the three divisions running
// side by side) and the level update, which registers its result. The input
// is ready again in the cycle after the update, while the previous result may
// still be waiting in the output register; the update of the next sample holds
// until that result has been taken. Configuration writes land at once and
// should only be made while no sample is in flight. The output is ten volts
// times the level in 2^-16 V units, from 0 to 655360.
module linear_adsr_envelope (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lae_pkg::CFGI_W-1:0]        i_cfg_index,
    input  logic [lae_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [lae_pkg::CV_W-1:0]   i_gate_volts,
    input  logic signed [lae_pkg::CV_W-1:0]   i_attack_cv,
    input  logic                              i_attack_cv_on,
    input  logic signed [lae_pkg::CV_W-1:0]   i_decay_cv,
    input  logic                              i_decay_cv_on,
    input  logic signed [lae_pkg::CV_W-1:0]   i_sustain_cv,
    input  logic                              i_sustain_cv_on,
    input  logic signed [lae_pkg::CV_W-1:0]   i_release_cv,
    input  logic                              i_release_cv_on,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [lae_pkg::OUT_W-1:0]         o_env_out
);

    lae_pkg::t_cmd    cmd;
    lae_pkg::t_status status;

    // The controller only steps the sequence; all arithmetic is in the datapath.
    lae_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    lae_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_gate_volts    (i_gate_volts),
        .i_attack_cv     (i_attack_cv),
        .i_attack_cv_on  (i_attack_cv_on),
        .i_decay_cv      (i_decay_cv),
        .i_decay_cv_on   (i_decay_cv_on),
        .i_sustain_cv    (i_sustain_cv),
        .i_sustain_cv_on (i_sustain_cv_on),
        .i_release_cv    (i_release_cv),
        .i_release_cv_on (i_release_cv_on),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_env_out       (o_env_out)
    );

`ifndef SYNTH
    // A sample in flight blocks the next one.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready stayed high after a transaction");

    // A fresh result appears only while the input side is closed.
    a_result_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without a sample in flight");

    // The envelope never exceeds ten volts.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_env_out <= 20'd655360))
        else $error("envelope output above full scale");
`endif

endmodule
